// ===== sv/svd_matrix_reconstruction_defines.svh =====
// assertion macros for the svd reconstruction block
// no dependencies
`ifndef SVD_MATRIX_RECONSTRUCTION_DEFINES_SVH
`define SVD_MATRIX_RECONSTRUCTION_DEFINES_SVH
`ifndef SYNTHESIS
`define SVR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("svr check");
`define SVR_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("svr check");
`else
`define SVR_ASSERT(label, clk, rst, prop)
`define SVR_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/svr_pkg.sv =====
// shared types, constants and arithmetic helpers for svd reconstruction
// no dependencies
package svr_pkg;
  localparam int MAX_DIM_DEF = 8;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_LOAD_W = 2'd2;
  localparam logic [1:0] CMD_START  = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

  // token travelling down the cell chain
  typedef struct packed {
    logic               vld;
    logic               lst;
    logic [2:0]         k;
    logic [2:0]         l;
    logic signed [63:0] acc;
  } tok_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== sv/svd_matrix_reconstruction.sv =====
// top level: stores, element sequencer, cell chain and output skid
// depends on svr_pkg, svr_cell, svd_matrix_reconstruction_defines.svh
//
// usage:
//  in channel carries load and start items (in_valid/in_stall, in_data).
//  loads of A, B, w are taken one per cycle while no start is in progress and produce no transfer.
//  a start issues the n*n output elements (k,l) in row-major order, one
//  token per cycle while no result is stalled at the output, into a chain
//  of MAX_DIM cells; cell j adds the term A[k][j]*B[l][j]*w[j] (cells at
//  j>=n add zero). each cell has three register stages, so a result
//  passes through the stages of every cell into the output queue before
//  it can transfer.
//  a start holds in_stall from its transfer until all of its results
//  have transferred and the output queue is empty.
//  while out_stall holds a result the issuer pauses; tokens already in the
//  chain keep moving and wait in the output queue, so nothing is lost.
//  reset clears control and sets dim_in_use to 8; in_stall is high during
//  reset. stores are undefined until written, so no clearing pass runs.
//  cfg_we/cfg_data write dim_in_use; 0 reads as 1, above MAX_DIM as MAX_DIM.
`include "svd_matrix_reconstruction_defines.svh"
module svd_matrix_reconstruction #(
  parameter int MAX_DIM = svr_pkg::MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  svr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output svr_pkg::out_item_t out_data
);
  localparam int DEPTH = 3 * MAX_DIM + 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [3:0] dim_in_use;
  logic [3:0] n;
  // stores kept in flops, read at fixed column lanes
  logic signed [31:0] a_st [MAX_DIM][MAX_DIM];
  logic signed [31:0] b_st [MAX_DIM][MAX_DIM];
  logic signed [31:0] w_st [MAX_DIM];

  logic       busy, issuing;
  logic [2:0] ik, il;
  logic [CW-1:0] inflight;
  logic       adv;
  logic       issue;

  svr_pkg::tok_t chain [MAX_DIM+1];
  // per-cell operand indices, taken undelayed from the token entering the cell
  logic [2:0] kd [MAX_DIM];
  logic [2:0] ld [MAX_DIM];

  always_comb begin
    n = dim_in_use;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MAX_DIM)) n = 4'(MAX_DIM);
  end

  assign in_stall = busy | rst;
  assign adv = !(out_valid && out_stall);
  assign issue = issuing && adv;

  always_ff @(posedge clk) begin
    if (rst) dim_in_use <= 4'd8;
    else if (cfg_we) dim_in_use <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      unique case (in_data.cmd)
        svr_pkg::CMD_LOAD_A:
          if (32'(in_data.row_index) < MAX_DIM && 32'(in_data.col_index) < MAX_DIM)
            a_st[in_data.row_index][in_data.col_index] <= in_data.load_value;
        svr_pkg::CMD_LOAD_B:
          if (32'(in_data.row_index) < MAX_DIM && 32'(in_data.col_index) < MAX_DIM)
            b_st[in_data.row_index][in_data.col_index] <= in_data.load_value;
        svr_pkg::CMD_LOAD_W:
          if (32'(in_data.row_index) < MAX_DIM)
            w_st[in_data.row_index] <= in_data.load_value;
        default: ;
      endcase
    end
  end

  // issue sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      issuing <= 1'b0;
      inflight <= '0;
      ik <= '0;
      il <= '0;
    end else begin
      if (in_valid && !busy && in_data.cmd == svr_pkg::CMD_START) begin
        busy <= 1'b1;
        issuing <= 1'b1;
        ik <= '0;
        il <= '0;
      end
      if (issue) begin
        if (4'(il) == n - 4'd1) begin
          il <= '0;
          if (4'(ik) == n - 4'd1) issuing <= 1'b0;
          else ik <= ik + 3'd1;
        end else il <= il + 3'd1;
      end
      inflight <= inflight + CW'(issue) - CW'(out_valid && !out_stall);
      if (busy && !issuing && inflight == '0 && !out_valid) busy <= 1'b0;
    end
  end

  assign chain[0] = {issue, (4'(ik) == n - 4'd1) && (4'(il) == n - 4'd1), ik, il, 64'd0};

  // issue pauses while a result is stalled at the output; tokens in flight
  // keep moving and collect in the output queue
  genvar g;
  for (g = 0; g < MAX_DIM; g++) begin : g_cell
    svr_pkg::tok_t tin_g;
    svr_pkg::tok_t tout_g;
    logic [2:0]    kk, lk;
    always_comb begin
      tin_g = chain[g];
    end
    // operands indexed by the token entering this cell
    assign kk = chain[g].k;
    assign lk = chain[g].l;
    assign kd[g] = kk;
    assign ld[g] = lk;
    svr_cell u_cell (
      .clk(clk), .rst(rst),
      .active(g < 32'(n)),
      .a_val(a_st[kd[g]][g]),
      .b_val(b_st[ld[g]][g]),
      .w_val(w_st[g]),
      .tin(tin_g),
      .tout(tout_g)
    );
    assign chain[g+1] = tout_g;
  end

  // output skid: the chain never stops, so results queue here
  localparam int QD = 4 * MAX_DIM;
  localparam int QW = $clog2(QD);
  svr_pkg::out_item_t q [QD];
  logic [QW-1:0] wp, rp;
  logic [QW:0]   qc;
  logic          pop, push;
  assign push = chain[MAX_DIM].vld;
  assign pop = out_valid && !out_stall;
  assign out_valid = qc != '0;
  assign out_data = q[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; qc <= '0;
    end else begin
      if (push) wp <= (32'(wp) == QD - 1) ? '0 : wp + 1'b1;
      if (pop) rp <= (32'(rp) == QD - 1) ? '0 : rp + 1'b1;
      qc <= qc + (QW+1)'(push) - (QW+1)'(pop);
    end
    if (push) begin
      q[wp].out_row <= chain[MAX_DIM].k;
      q[wp].out_col <= chain[MAX_DIM].l;
      q[wp].out_value <= svr_pkg::sat32(chain[MAX_DIM].acc);
      q[wp].last <= chain[MAX_DIM].lst;
    end
  end

  `SVR_ASSERT(a_no_accept_busy, clk, rst, busy |-> in_stall)
  `SVR_ASSERT(a_q_bound, clk, rst, qc <= (QW+1)'(QD))
  `SVR_ASSERT(a_out_only_busy, clk, rst, out_valid |-> busy)
endmodule

// ===== sv/svr_cell.sv =====
// one multiply-accumulate cell of the chain, owns term j of the dot product
// depends on svr_pkg
module svr_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               active,
  input  logic signed [31:0] a_val,
  input  logic signed [31:0] b_val,
  input  logic signed [31:0] w_val,
  input  svr_pkg::tok_t      tin,
  output svr_pkg::tok_t      tout
);
  // three stages: a*b, rescale*w, rescale+add
  svr_pkg::tok_t      t1, t2;
  logic signed [63:0] m1, m2;
  logic signed [31:0] w1;
  logic signed [31:0] p1;

  assign p1 = svr_pkg::sat32(m1 >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.vld <= 1'b0;
      t2.vld <= 1'b0;
      tout.vld <= 1'b0;
    end else begin
      t1.vld <= tin.vld;
      t2.vld <= t1.vld;
      tout.vld <= t2.vld;
    end
    t1.lst <= tin.lst; t1.k <= tin.k; t1.l <= tin.l; t1.acc <= tin.acc;
    t2.lst <= t1.lst;  t2.k <= t1.k;  t2.l <= t1.l;  t2.acc <= t1.acc;
    tout.lst <= t2.lst; tout.k <= t2.k; tout.l <= t2.l;
    m1 <= active ? 64'(a_val) * 64'(b_val) : 64'sd0;
    // idle cells force w to zero so unused scale entries never reach the sum
    w1 <= active ? w_val : 32'sd0;
    m2 <= 64'(p1) * 64'(w1);
    tout.acc <= t2.acc + 64'(svr_pkg::sat32(m2 >>> 16));
  end
endmodule

// ===== test/tb.sv =====
// testbench for svd_matrix_reconstruction: loads A, B and w, runs starts and
// checks every result element against an in-bench predictor of A*diag(w)*B^T
// depends on svr_pkg and the svd_matrix_reconstruction top level
`timescale 1ns / 1ps
module tb;
  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [3:0] cfg_data;
  logic      in_valid;
  logic      in_stall;
  svr_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  svr_pkg::out_item_t out_data;

  svd_matrix_reconstruction DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor copy of the block state
  logic signed [31:0] a_mat [0:7][0:7];
  logic signed [31:0] b_mat [0:7][0:7];
  logic signed [31:0] w_vec [0:7];
  int unsigned        dim_reg;

  // stores the stimulus builder tracks, so a start never reads an unwritten entry
  bit a_seen [0:7][0:7];
  bit b_seen [0:7][0:7];
  bit w_seen [0:7];

  svr_pkg::in_item_t  pending_items [$];
  svr_pkg::out_item_t expected_elems [$];

  int  cycle_count = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  starts_sent = 0;
  int  items_sent = 0;
  bit  hold_sender;
  int  send_gap;
  int  recv_gap;
  int  send_draw;
  int  recv_draw;

  localparam int CYCLE_LIMIT = 2000000;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // apply one accepted item to the predictor; a start queues n*n elements
  task automatic predict_item(input svr_pkg::in_item_t it);
    int n;
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    svr_pkg::out_item_t e;
    case (it.cmd)
      svr_pkg::CMD_LOAD_A: a_mat[it.row_index][it.col_index] = it.load_value;
      svr_pkg::CMD_LOAD_B: b_mat[it.row_index][it.col_index] = it.load_value;
      svr_pkg::CMD_LOAD_W: w_vec[it.row_index] = it.load_value;
      default: begin
        n = (dim_reg < 1) ? 1 : (dim_reg > 8) ? 8 : dim_reg;
        for (int k = 0; k < n; k++) begin
          for (int l = 0; l < n; l++) begin
            acc = 0;
            for (int j = 0; j < n; j++) begin
              // arithmetic shift gives floor rounding
              prod = 64'(a_mat[k][j]) * 64'(b_mat[l][j]);
              p1 = clamp32(prod >>> 16);
              prod = 64'(p1) * 64'(w_vec[j]);
              p2 = clamp32(prod >>> 16);
              acc = acc + 64'(p2);
            end
            e.out_row = 3'(k);
            e.out_col = 3'(l);
            e.out_value = clamp32(acc);
            e.last = (k == n - 1) && (l == n - 1);
            expected_elems = {expected_elems, e};
          end
        end
      end
    endcase
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic svr_pkg::in_item_t make_item(input logic [1:0] c, input int r,
                                                  input int col,
                                                  input logic signed [31:0] v);
    svr_pkg::in_item_t it;
    it.cmd = c;
    it.row_index = 3'(r);
    it.col_index = 3'(col);
    it.load_value = v;
    return it;
  endfunction

  task automatic queue_item(input svr_pkg::in_item_t it);
    if (it.cmd == svr_pkg::CMD_LOAD_A) a_seen[it.row_index][it.col_index] = 1'b1;
    if (it.cmd == svr_pkg::CMD_LOAD_B) b_seen[it.row_index][it.col_index] = 1'b1;
    if (it.cmd == svr_pkg::CMD_LOAD_W) w_seen[it.row_index] = 1'b1;
    pending_items = {pending_items, it};
  endtask

  // fill all entries below n that were never written, then queue a start
  task automatic queue_start(input int n);
    for (int r = 0; r < n; r++) begin
      if (!w_seen[r])
        queue_item(make_item(svr_pkg::CMD_LOAD_W, r, $urandom_range(0, 7), rand_value()));
      for (int c = 0; c < n; c++) begin
        if (!a_seen[r][c]) queue_item(make_item(svr_pkg::CMD_LOAD_A, r, c, rand_value()));
        if (!b_seen[r][c]) queue_item(make_item(svr_pkg::CMD_LOAD_B, r, c, rand_value()));
      end
    end
    queue_item(make_item(svr_pkg::CMD_START, $urandom_range(0, 7), $urandom_range(0, 7),
                         rand_value()));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_elems.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_dim(input logic [3:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_reg = d;
  endtask

  // driver: one transfer per accepted item, random gap before each
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else if (in_valid && !in_stall) begin
      predict_item(in_data);
      items_sent <= items_sent + 1;
      if (in_data.cmd == svr_pkg::CMD_START) starts_sent <= starts_sent + 1;
      void'(pending_items.pop_front());
      send_draw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
      if (send_draw == 0 && pending_items.size() != 0 && !hold_sender) begin
        in_data <= pending_items[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      send_gap <= (send_draw == 0) ? 0 : send_draw - 1;
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0 && !hold_sender) begin
        in_data <= pending_items[0];
        in_valid <= 1'b1;
      end
    end
  end

  // monitor: compare each transfer with the oldest expected element
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_elems.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected element %p", out_data);
        end else begin
          if (out_data !== expected_elems[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("element mismatch: expected %p got %p", expected_elems[0], out_data);
          end
          void'(expected_elems.pop_front());
        end
        recv_draw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
        recv_gap <= recv_draw;
        out_stall <= (recv_draw != 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= (recv_gap > 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 4'd0;
    hold_sender = 1'b0;
    dim_reg = 8;
    for (int r = 0; r < 8; r++) begin
      w_seen[r] = 1'b0;
      for (int c = 0; c < 8; c++) begin
        a_seen[r][c] = 1'b0;
        b_seen[r][c] = 1'b0;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme values at the corners, then a start at reset size 8
    queue_item(make_item(svr_pkg::CMD_LOAD_A, 0, 0, 32'sh7fffffff));
    queue_item(make_item(svr_pkg::CMD_LOAD_A, 7, 7, 32'sh80000000));
    queue_item(make_item(svr_pkg::CMD_LOAD_B, 0, 0, 32'sh7fffffff));
    queue_item(make_item(svr_pkg::CMD_LOAD_B, 7, 7, 32'sh80000000));
    queue_item(make_item(svr_pkg::CMD_LOAD_W, 0, 7, 32'sh7fffffff));
    queue_item(make_item(svr_pkg::CMD_LOAD_W, 7, 0, 32'sh80000000));
    queue_item(make_item(svr_pkg::CMD_LOAD_A, 3, 5, 32'sh00010000));
    queue_item(make_item(svr_pkg::CMD_LOAD_W, 5, 2, -32'sh00008000));
    queue_start(8);
    wait_drained();

    // dimension zero reads as one, fifteen as eight
    set_dim(4'd0);
    queue_start(1);
    wait_drained();
    set_dim(4'd15);
    queue_start(8);
    wait_drained();

    // random phases over several sizes; load rows mostly inside the active size
    for (int phase = 0; phase < 5; phase++) begin
      set_dim(phase == 0 ? 4'd1 : phase == 1 ? 4'd8 : 4'($urandom_range(2, 7)));
      n = (dim_reg < 1) ? 1 : (dim_reg > 8) ? 8 : dim_reg;
      for (int i = 0; i < 36; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_start(n);
        end else begin
          queue_item(make_item(2'($urandom_range(0, 2)),
                               $urandom_range(0, 3) == 0 ? $urandom_range(0, 7)
                                                         : $urandom_range(0, n - 1),
                               $urandom_range(0, 7), rand_value()));
        end
        // once, hold the sender until all results are back
        if (phase == 3 && i == 18) begin
          queue_start(n);
          while (pending_items.size() != 0) @(posedge clk);
          hold_sender = 1'b1;
          while (expected_elems.size() != 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      queue_start(n);
      wait_drained();
    end

    $display("covered %0d items including %0d starts, %0d result elements checked",
             items_sent, starts_sent, results_seen);
    $display("sizes one and eight, random sizes between, out-of-range sizes, "
             , "value extremes and random stalls");
    if (mismatches == 0 && expected_elems.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
